// ===== hdl/cle_pkg.sv =====
// ----------------------------------------------------------------------------
// cle_pkg: shared definitions for the circular list engine
// Operation and status codes, field widths and the control/status structs
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int CLE_CAPACITY = 256;
  localparam int OP_W         = 3;
  localparam int DATA_W       = 32;
  localparam int COUNT_W      = 9;
  localparam int STATUS_W     = 2;

  // operation codes carried by a request
  localparam logic [OP_W-1:0] OP_PEEK       = 3'd0;
  localparam logic [OP_W-1:0] OP_ROT_NEXT   = 3'd1;
  localparam logic [OP_W-1:0] OP_ROT_PREV   = 3'd2;
  localparam logic [OP_W-1:0] OP_INS_BEFORE = 3'd3;
  localparam logic [OP_W-1:0] OP_INS_AFTER  = 3'd4;
  localparam logic [OP_W-1:0] OP_DELETE     = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;  // capture the request fields
    logic update;  // first write pass: allocate or free, move current
    logic link;    // second write pass: splice the neighbour links
    logic load;    // load the result register
  } cle_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } cle_sts_t;

endpackage

// ===== hdl/cle_req_if.sv =====
// ----------------------------------------------------------------------------
// cle_req_if: request channel of the circular list engine
// Valid/ready handshake carrying the operation code and the insert value.
// ----------------------------------------------------------------------------
interface cle_req_if import cle_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

// ===== hdl/cle_rsp_if.sv =====
// ----------------------------------------------------------------------------
// cle_rsp_if: result channel of the circular list engine
// Valid/ready handshake carrying the list state after each request.
// ----------------------------------------------------------------------------
interface cle_rsp_if import cle_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] current_value;
  logic [COUNT_W-1:0]       element_count;
  logic                     is_empty;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, output current_value, output element_count,
                  output is_empty, output status, input ready);
  modport sink   (input valid, input current_value, input element_count,
                  input is_empty, input status, output ready);
endinterface

// ===== hdl/circular_list_engine.sv =====
// ----------------------------------------------------------------------------
// circular_list_engine: circular doubly linked list over a fixed node pool
// Each request passes through update, link and result phases; the result
// register is loaded once the output is free. A new request is taken only
// after the previous result has been loaded.
// Reset: synchronous; empties the list and pool counters, memories untouched.
// ----------------------------------------------------------------------------
module circular_list_engine import cle_pkg::*; #(
  parameter int CAPACITY = CLE_CAPACITY
) (
  input logic        clk,
  input logic        rst,
  cle_req_if.sink    req,
  cle_rsp_if.source  rsp
);

  cle_cmd_t cmd;
  cle_sts_t sts;

  // sequence each request
  cle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // hold the list and build results
  cle_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .req_op            (req.op),
    .req_value         (req.value),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_current_value (rsp.current_value),
    .rsp_element_count (rsp.element_count),
    .rsp_is_empty      (rsp.is_empty),
    .rsp_status        (rsp.status)
  );

endmodule

// ===== hdl/cle_ctrl.sv =====
// ----------------------------------------------------------------------------
// cle_ctrl: sequencing controller of the circular list engine
// Steps each request through update, link and result phases and issues
// the matching commands to the datapath.
// ----------------------------------------------------------------------------
module cle_ctrl import cle_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  cle_sts_t sts,
  output cle_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_UPDATE = 4'b0010,
    S_LINK   = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // advance through the phases; hold in result until the output is free
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (req_valid) state_next = S_UPDATE;
      S_UPDATE: state_next = S_LINK;
      S_LINK:   state_next = S_RESULT;
      S_RESULT: if (sts.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // drive commands from the current phase
  assign req_ready  = (state == S_IDLE);
  assign cmd.accept = req_valid && (state == S_IDLE);
  assign cmd.update = (state == S_UPDATE);
  assign cmd.link   = (state == S_LINK);
  assign cmd.load   = (state == S_RESULT) && sts.out_free;

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> sts.out_free)
    else $error("result loaded while output register still occupied");

  a_accept_starts_update: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> cmd.update)
    else $error("accepted request not followed by update phase");

  a_update_then_link: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> cmd.link && !req_ready)
    else $error("update phase not followed by link phase");

endmodule

// ===== hdl/cle_datapath.sv =====
// ----------------------------------------------------------------------------
// cle_datapath: node pool, link memories and list registers
// Holds the link, value and free-stack memories, the current pointer and
// counters, and the result register; acts on controller commands.
// ----------------------------------------------------------------------------
module cle_datapath import cle_pkg::*; #(
  parameter int CAPACITY = CLE_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cle_cmd_t                 cmd,
  output cle_sts_t                 sts,
  input  logic [OP_W-1:0]          req_op,
  input  logic signed [DATA_W-1:0] req_value,
  output logic                     rsp_valid,
  input  logic                     rsp_ready,
  output logic signed [DATA_W-1:0] rsp_current_value,
  output logic [COUNT_W-1:0]       rsp_element_count,
  output logic                     rsp_is_empty,
  output logic [STATUS_W-1:0]      rsp_status
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // memories
  logic [IW-1:0]            next_link  [CAPACITY];
  logic [IW-1:0]            prev_link  [CAPACITY];
  logic signed [DATA_W-1:0] node_value [CAPACITY];
  logic [IW-1:0]            free_stack [CAPACITY];

  // registered read data
  logic [IW-1:0]            nx_rd;
  logic [IW-1:0]            pv_rd;
  logic [IW-1:0]            fs_rd;
  logic signed [DATA_W-1:0] val_rd;

  // list state
  logic [IW-1:0] cur;
  logic [CW-1:0] count;
  logic [CW-1:0] free_top;
  logic [CW-1:0] fresh_index;
  logic [IW-1:0] cur_next;
  logic [CW-1:0] count_next;
  logic [CW-1:0] free_top_next;
  logic [CW-1:0] fresh_index_next;

  // request and per-item working registers
  logic [OP_W-1:0]          op_q;
  logic signed [DATA_W-1:0] value_q;
  logic [STATUS_W-1:0]      status_q;
  logic [STATUS_W-1:0]      status_next;
  logic                     link_q;
  logic                     link_next;
  logic [IW-1:0]            node_q;
  logic [IW-1:0]            node_next;
  logic [IW-1:0]            nb_q;
  logic [IW-1:0]            nb_next;

  // write ports
  logic                     nl_we;
  logic [IW-1:0]            nl_waddr;
  logic [IW-1:0]            nl_wdata;
  logic                     pl_we;
  logic [IW-1:0]            pl_waddr;
  logic [IW-1:0]            pl_wdata;
  logic                     nv_we;
  logic [IW-1:0]            nv_waddr;
  logic                     fs_we;

  logic [CW-1:0]     free_top_m1;
  logic [IW-1:0]     alloc_node;
  logic [CW+8:0]     count_wide;

  assign free_top_m1 = free_top - 1'b1;
  assign alloc_node  = (free_top != '0) ? fs_rd : fresh_index[IW-1:0];

  // decode the operation into memory writes and register updates
  always_comb begin
    cur_next         = cur;
    count_next       = count;
    free_top_next    = free_top;
    fresh_index_next = fresh_index;
    status_next      = status_q;
    link_next        = link_q;
    node_next        = node_q;
    nb_next          = nb_q;
    nl_we            = 1'b0;
    nl_waddr         = '0;
    nl_wdata         = '0;
    pl_we            = 1'b0;
    pl_waddr         = '0;
    pl_wdata         = '0;
    nv_we            = 1'b0;
    nv_waddr         = '0;
    fs_we            = 1'b0;

    if (cmd.update) begin
      status_next = ST_OK;
      link_next   = 1'b0;
      unique case (op_q)
        OP_PEEK: begin
          if (count == '0) status_next = ST_EMPTY;
        end
        OP_ROT_NEXT: begin
          if (count != '0) cur_next = nx_rd;
        end
        OP_ROT_PREV: begin
          if (count != '0) cur_next = pv_rd;
        end
        OP_INS_BEFORE, OP_INS_AFTER: begin
          if (count >= CAP_C) begin
            status_next = ST_FULL;
          end else begin
            // pop the free stack first, else take a fresh node
            if (free_top != '0) begin
              free_top_next = free_top_m1;
            end else begin
              fresh_index_next = fresh_index + 1'b1;
            end
            nv_we     = 1'b1;
            nv_waddr  = alloc_node;
            node_next = alloc_node;
            nl_we     = 1'b1;
            nl_waddr  = alloc_node;
            pl_we     = 1'b1;
            pl_waddr  = alloc_node;
            if (count == '0) begin
              nl_wdata = alloc_node;
              pl_wdata = alloc_node;
              cur_next = alloc_node;
            end else if (op_q == OP_INS_AFTER) begin
              nl_wdata  = nx_rd;
              pl_wdata  = cur;
              nb_next   = nx_rd;
              link_next = 1'b1;
            end else begin
              nl_wdata  = cur;
              pl_wdata  = pv_rd;
              nb_next   = pv_rd;
              link_next = 1'b1;
            end
            count_next = count + 1'b1;
          end
        end
        OP_DELETE: begin
          if (count == '0) begin
            status_next = ST_EMPTY;
          end else begin
            if (count == CW'(1)) begin
              cur_next = '0;
            end else begin
              nl_we    = 1'b1;
              nl_waddr = pv_rd;
              nl_wdata = nx_rd;
              pl_we    = 1'b1;
              pl_waddr = nx_rd;
              pl_wdata = pv_rd;
              cur_next = nx_rd;
            end
            // return the node to the free stack
            if (free_top < CAP_C) begin
              fs_we         = 1'b1;
              free_top_next = free_top + 1'b1;
            end
            count_next = count - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.link && link_q) begin
      // splice the new node between current and its neighbour
      nl_we = 1'b1;
      pl_we = 1'b1;
      if (op_q == OP_INS_AFTER) begin
        pl_waddr = nb_q;
        pl_wdata = node_q;
        nl_waddr = cur;
        nl_wdata = node_q;
      end else begin
        nl_waddr = nb_q;
        nl_wdata = node_q;
        pl_waddr = cur;
        pl_wdata = node_q;
      end
    end
  end

  // memory write and read ports
  always_ff @(posedge clk) begin
    if (nl_we) next_link[nl_waddr] <= nl_wdata;
    nx_rd <= next_link[cur];
  end

  always_ff @(posedge clk) begin
    if (pl_we) prev_link[pl_waddr] <= pl_wdata;
    pv_rd <= prev_link[cur];
  end

  always_ff @(posedge clk) begin
    if (nv_we) node_value[nv_waddr] <= value_q;
    val_rd <= node_value[cur];
  end

  always_ff @(posedge clk) begin
    if (fs_we) free_stack[free_top[IW-1:0]] <= cur;
    fs_rd <= free_stack[free_top_m1[IW-1:0]];
  end

  // list control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur         <= '0;
      count       <= '0;
      free_top    <= '0;
      fresh_index <= '0;
      link_q      <= 1'b0;
    end else begin
      cur         <= cur_next;
      count       <= count_next;
      free_top    <= free_top_next;
      fresh_index <= fresh_index_next;
      link_q      <= link_next;
    end
  end

  // request capture and per-item payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q    <= req_op;
      value_q <= req_value;
    end
    status_q <= status_next;
    node_q   <= node_next;
    nb_q     <= nb_next;
  end

  // result register
  assign count_wide = {{9{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rsp_current_value <= (count != '0) ? val_rd : '0;
      rsp_element_count <= count_wide[COUNT_W-1:0];
      rsp_is_empty      <= (count == '0);
      rsp_status        <= status_q;
    end
  end

  assign sts.out_free = !rsp_valid || rsp_ready;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C)
    else $error("element count exceeds pool capacity");

  a_pool_conserved: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, count} + {1'b0, free_top}) == {1'b0, fresh_index})
    else $error("node pool accounting lost a node");

  a_full_only_at_capacity: assert property (@(posedge clk) disable iff (rst)
    cmd.update && (status_next == ST_FULL) |-> count == CAP_C)
    else $error("full status raised below capacity");

endmodule

// ===== bench/tb_circular_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_list_engine: self-checking bench for the circular list engine
// Drives operation requests through the request channel and keeps a shadow
// copy of the node pool, links, free stack and current pointer. Every request
// that is accepted yields one expected result. Each returned result is checked
// field by field against the oldest expected one. A directed opening covers
// the empty-list cases and the extreme values. Random traffic then steers the
// list between empty and a full pool under changing back-pressure.
// ----------------------------------------------------------------------------
module tb_circular_list_engine;
  import cle_pkg::*;

  localparam int IDX_W       = $clog2(CLE_CAPACITY);
  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_LEN   = 660;

  // spare operation codes: the block must leave the list alone
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [DATA_W-1:0] current_value;
    logic [COUNT_W-1:0]       element_count;
    logic                     is_empty;
    logic [STATUS_W-1:0]      status;
  } list_view_t;

  // shadow of the list plus the queue of list views still to be returned
  class list_tracker;
    logic [IDX_W-1:0]         next_link  [CLE_CAPACITY];
    logic [IDX_W-1:0]         prev_link  [CLE_CAPACITY];
    logic signed [DATA_W-1:0] node_value [CLE_CAPACITY];
    logic [IDX_W-1:0]         free_stack [CLE_CAPACITY];
    logic [IDX_W-1:0]         cur;
    logic [COUNT_W-1:0]       count;
    logic [COUNT_W-1:0]       free_top;
    logic [COUNT_W-1:0]       fresh;
    list_view_t               awaited_views[$];
    int                       errors;

    function new();
      cur      = '0;
      count    = '0;
      free_top = '0;
      fresh    = '0;
      errors   = 0;
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // splice a new node next to current; refuse when the pool is full
    function logic [STATUS_W-1:0] insert_node(logic signed [DATA_W-1:0] value, bit after);
      logic [IDX_W-1:0] n;
      logic [IDX_W-1:0] nb;
      if (count >= CLE_CAPACITY) return ST_FULL;
      if (free_top != 0) begin
        free_top--;
        n = free_stack[free_top[IDX_W-1:0]];
      end else begin
        n = fresh[IDX_W-1:0];
        fresh++;
      end
      node_value[n] = value;
      if (count == 0) begin
        next_link[n] = n;
        prev_link[n] = n;
        cur          = n;
      end else if (after) begin
        nb             = next_link[cur];
        prev_link[n]   = cur;
        next_link[n]   = nb;
        prev_link[nb]  = n;
        next_link[cur] = n;
      end else begin
        nb             = prev_link[cur];
        next_link[n]   = cur;
        prev_link[n]   = nb;
        next_link[nb]  = n;
        prev_link[cur] = n;
      end
      count++;
      return ST_OK;
    endfunction

    // apply one accepted request and queue the list view it must produce
    function void note_request(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value);
      logic [STATUS_W-1:0] st;
      logic [IDX_W-1:0]    gone;
      logic [IDX_W-1:0]    p;
      logic [IDX_W-1:0]    nx;
      list_view_t          view;
      st = ST_OK;
      case (op)
        OP_PEEK: begin
          if (count == 0) st = ST_EMPTY;
        end
        OP_ROT_NEXT: begin
          if (count != 0) cur = next_link[cur];
        end
        OP_ROT_PREV: begin
          if (count != 0) cur = prev_link[cur];
        end
        OP_INS_BEFORE: st = insert_node(value, 1'b0);
        OP_INS_AFTER:  st = insert_node(value, 1'b1);
        OP_DELETE: begin
          if (count == 0) begin
            st = ST_EMPTY;
          end else begin
            // unlink current, advance to its successor, recycle the node
            gone = cur;
            if (count == 1) begin
              cur = '0;
            end else begin
              p            = prev_link[cur];
              nx           = next_link[cur];
              next_link[p] = nx;
              prev_link[nx] = p;
              cur          = nx;
            end
            free_stack[free_top[IDX_W-1:0]] = gone;
            free_top++;
            count--;
          end
        end
        default: ;
      endcase
      view.current_value = (count != 0) ? node_value[cur] : '0;
      view.element_count = count;
      view.is_empty      = (count == 0);
      view.status        = st;
      awaited_views.push_back(view);
    endfunction

    task check_result(list_view_t got);
      list_view_t want;
      if (awaited_views.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding (value %0d count %0d)",
                                  got.current_value, got.element_count));
        return;
      end
      want = awaited_views.pop_front();
      if (got.current_value !== want.current_value)
        report_mismatch($sformatf("current_value got %0d want %0d",
                                  got.current_value, want.current_value));
      if (got.element_count !== want.element_count)
        report_mismatch($sformatf("element_count got %0d want %0d",
                                  got.element_count, want.element_count));
      if (got.is_empty !== want.is_empty)
        report_mismatch($sformatf("is_empty got %0b want %0b", got.is_empty, want.is_empty));
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
    endtask
  endclass

  logic clk;
  logic rst;

  cle_req_if req_ch ();
  cle_rsp_if rsp_ch ();

  circular_list_engine DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  list_tracker tracker;
  int unsigned req_idle_pct;
  int unsigned rsp_stall_pct;
  int          fill_target;
  int          idle_run;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // randomly hold off the result channel
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
  end

  // check results and watch for a stalled run
  always @(posedge clk) begin
    if (rst) begin
      idle_run <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready)
        tracker.check_result(list_view_t'{rsp_ch.current_value, rsp_ch.element_count,
                                          rsp_ch.is_empty, rsp_ch.status});
      if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready)) begin
        idle_run <= 0;
      end else if (idle_run >= STALL_LIMIT) begin
        $display("[%0t] no handshake for %0d cycles", $realtime, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  // offer one request, with random idle cycles first, and hold until taken
  task automatic send_request(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value);
    while ($urandom_range(99) < req_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op    <= op;
    req_ch.value <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    tracker.note_request(op, value);
  endtask

  // drop valid and hold until every outstanding result is back
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (tracker.awaited_views.size() != 0) @(posedge clk);
  endtask

  // steer the list size towards a moving target, with random noise mixed in
  task automatic run_random(int unsigned n);
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
    int unsigned              roll;
    bit                       grow;
    repeat (n) begin
      roll = $urandom_range(99);
      grow = (int'(tracker.count) < fill_target);
      if (int'(tracker.count) == fill_target) begin
        if ($urandom_range(7) == 0) begin
          case ($urandom_range(3))
            0:       fill_target = CLE_CAPACITY;
            1:       fill_target = 0;
            default: fill_target = $urandom_range(1, 12);
          endcase
        end
        op = OP_W'($urandom_range(7));
      end else if (roll < 75) begin
        op = grow ? ($urandom_range(1) ? OP_INS_AFTER : OP_INS_BEFORE) : OP_DELETE;
      end else if (roll < 80) begin
        op = grow ? OP_DELETE : ($urandom_range(1) ? OP_INS_AFTER : OP_INS_BEFORE);
      end else begin
        op = OP_W'($urandom_range(7));
      end
      case ($urandom_range(9))
        0:       value = {1'b1, {(DATA_W-1){1'b0}}};
        1:       value = {1'b0, {(DATA_W-1){1'b1}}};
        2:       value = '0;
        3:       value = '1;
        default: value = $urandom;
      endcase
      send_request(op, value);
    end
  endtask

  initial begin
    tracker       = new();
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.op    <= OP_PEEK;
    req_ch.value <= '0;
    req_idle_pct  = 37;
    rsp_stall_pct = 78;
    fill_target   = CLE_CAPACITY;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty list: peek and delete fail, rotations and spare codes do nothing
    send_request(OP_PEEK,     32'sd0);
    send_request(OP_DELETE,   32'sd0);
    send_request(OP_ROT_NEXT, 32'sd0);
    send_request(OP_ROT_PREV, 32'sd0);
    send_request(OP_SPARE_LO, 32'sd0);
    send_request(OP_SPARE_HI, '1);
    // first insert becomes current; later inserts leave current in place
    send_request(OP_INS_AFTER,  {1'b0, {(DATA_W-1){1'b1}}});
    send_request(OP_INS_BEFORE, {1'b1, {(DATA_W-1){1'b0}}});
    send_request(OP_INS_AFTER,  32'sd0);
    send_request(OP_INS_BEFORE, -32'sd1);
    send_request(OP_ROT_NEXT,   32'sd0);
    send_request(OP_ROT_PREV,   32'sd0);
    send_request(OP_ROT_PREV,   32'sd0);
    send_request(OP_PEEK,       32'sd0);
    // delete down to empty, successor taking over each time
    send_request(OP_DELETE, 32'sd0);
    send_request(OP_DELETE, 32'sd0);
    send_request(OP_DELETE, 32'sd0);
    send_request(OP_DELETE, 32'sd0);
    send_request(OP_DELETE, 32'sd0);
    // reuse recycled nodes
    send_request(OP_INS_BEFORE, 32'sh5555_5555);
    send_request(OP_INS_AFTER,  32'shAAAA_AAAA);
    send_request(OP_SPARE_HI,   32'sd7);
    send_request(OP_DELETE,     32'sd0);

    run_random(PHASE_LEN);
    settle();
    req_idle_pct  = 78;
    rsp_stall_pct = 37;
    run_random(PHASE_LEN);
    settle();
    req_idle_pct  = 0;
    rsp_stall_pct = 0;
    fill_target   = CLE_CAPACITY;
    run_random(PHASE_LEN);
    settle();

    // allow any stray late result to surface
    repeat (20) @(posedge clk);
    if (tracker.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
